[rtl/spf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spf_pkg
// Types and constants shared by the smoothed pen position follower blocks.
// ----------------------------------------------------------------------------
package spf_pkg;

  // Register map, byte address = 4 * index
  typedef enum logic [2:0] {
    REG_SMOOTHING_WEIGHT = 3'd0,
    REG_TARGET_X         = 3'd1,
    REG_TARGET_Y         = 3'd2,
    REG_GAIN_X           = 3'd3,
    REG_GAIN_Y           = 3'd4,
    REG_TRAVEL_LIMIT_X   = 3'd5,
    REG_TRAVEL_LIMIT_Y   = 3'd6,
    REG_MIN_INTERVAL_MS  = 3'd7
  } reg_idx_e;

  localparam int unsigned RegIdxW = 3;
  localparam int unsigned PaddrW  = RegIdxW + 2;

  localparam logic [15:0]        SmoothingWeightRst = 16'd45875;
  localparam logic [15:0]        TargetRst          = 16'd960;
  localparam logic signed [23:0] GainXRst           = 24'sd6588;
  localparam logic signed [23:0] GainYRst           = -24'sd4949;
  localparam logic [9:0]         TravelLimitRst     = 10'd500;
  localparam logic [7:0]         MinIntervalRst     = 8'd5;

  // 2.0 mm in Q.8
  localparam logic signed [33:0] DeadbandQ8 = 34'sd512;
  localparam logic [48:0]        HalfQ16    = 49'd32768;
  localparam logic [56:0]        HalfQ24    = 57'd8388608;

  typedef struct packed {
    logic [15:0]        smoothing_weight;
    logic [15:0]        target_x;
    logic [15:0]        target_y;
    logic signed [23:0] gain_x;
    logic signed [23:0] gain_y;
    logic [9:0]         travel_limit_x;
    logic [9:0]         travel_limit_y;
    logic [7:0]         min_interval_ms;
  } cfg_t;

  // Operand pair fed to the shared multiplier
  typedef enum logic [1:0] {
    MUL_W_PREV     = 2'd0,
    MUL_WC_PEN     = 2'd1,
    MUL_DELTA_GAIN = 2'd2
  } mul_sel_e;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef struct packed {
    logic     capture;
    mul_sel_e mul_sel;
    logic     mul_axis;
    logic     acc_load;
    logic     sm_write;
    logic     mv_write;
    logic     wr_axis;
    logic     commit;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/spf_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spf_if
// Valid/ready channels for pen samples and follower results.
// ----------------------------------------------------------------------------
interface spf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [31:0] time_ms;

  modport source (output valid, output pen_x, output pen_y, output time_ms, input ready);
  modport sink   (input valid, input pen_x, input pen_y, input time_ms, output ready);
endinterface

interface spf_out_if;
  logic        valid;
  logic        ready;
  logic        position_updated;
  logic        command_issued;
  logic [17:0] position_x;
  logic [17:0] position_y;

  modport source (output valid, output position_updated, output command_issued,
                  output position_x, output position_y, input ready);
  modport sink   (input valid, input position_updated, input command_issued,
                  input position_x, input position_y, output ready);
endinterface
`default_nettype wire

[rtl/spf_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spf_cfg
// APB-style configuration registers of the pen position follower.
// ----------------------------------------------------------------------------
module spf_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spf_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output spf_pkg::cfg_t                    cfg_o
);

  spf_pkg::cfg_t     cfg_q, cfg_d;
  spf_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = spf_pkg::reg_idx_e'(paddr[spf_pkg::PaddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        spf_pkg::REG_SMOOTHING_WEIGHT: cfg_d.smoothing_weight = pwdata[15:0];
        spf_pkg::REG_TARGET_X:         cfg_d.target_x         = pwdata[15:0];
        spf_pkg::REG_TARGET_Y:         cfg_d.target_y         = pwdata[15:0];
        spf_pkg::REG_GAIN_X:           cfg_d.gain_x           = pwdata[23:0];
        spf_pkg::REG_GAIN_Y:           cfg_d.gain_y           = pwdata[23:0];
        spf_pkg::REG_TRAVEL_LIMIT_X:   cfg_d.travel_limit_x   = pwdata[9:0];
        spf_pkg::REG_TRAVEL_LIMIT_Y:   cfg_d.travel_limit_y   = pwdata[9:0];
        spf_pkg::REG_MIN_INTERVAL_MS:  cfg_d.min_interval_ms  = pwdata[7:0];
        default:                       cfg_d                  = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      spf_pkg::REG_SMOOTHING_WEIGHT: prdata = {16'd0, cfg_q.smoothing_weight};
      spf_pkg::REG_TARGET_X:         prdata = {16'd0, cfg_q.target_x};
      spf_pkg::REG_TARGET_Y:         prdata = {16'd0, cfg_q.target_y};
      spf_pkg::REG_GAIN_X:           prdata = {{8{cfg_q.gain_x[23]}}, cfg_q.gain_x};
      spf_pkg::REG_GAIN_Y:           prdata = {{8{cfg_q.gain_y[23]}}, cfg_q.gain_y};
      spf_pkg::REG_TRAVEL_LIMIT_X:   prdata = {22'd0, cfg_q.travel_limit_x};
      spf_pkg::REG_TRAVEL_LIMIT_Y:   prdata = {22'd0, cfg_q.travel_limit_y};
      spf_pkg::REG_MIN_INTERVAL_MS:  prdata = {24'd0, cfg_q.min_interval_ms};
      default:                       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.smoothing_weight <= spf_pkg::SmoothingWeightRst;
      cfg_q.target_x         <= spf_pkg::TargetRst;
      cfg_q.target_y         <= spf_pkg::TargetRst;
      cfg_q.gain_x           <= spf_pkg::GainXRst;
      cfg_q.gain_y           <= spf_pkg::GainYRst;
      cfg_q.travel_limit_x   <= spf_pkg::TravelLimitRst;
      cfg_q.travel_limit_y   <= spf_pkg::TravelLimitRst;
      cfg_q.min_interval_ms  <= spf_pkg::MinIntervalRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

[rtl/spf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spf_ctrl
// Sequencer: walks one request through the shared multiplier schedule and
// owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module spf_ctrl (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output spf_pkg::cmd_t cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MUL_WX = 9'b000000010,
    ST_MUL_PX = 9'b000000100,
    ST_MUL_WY = 9'b000001000,
    ST_MUL_PY = 9'b000010000,
    ST_MUL_GX = 9'b000100000,
    ST_MUL_GY = 9'b001000000,
    ST_RND_Y  = 9'b010000000,
    ST_COMMIT = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.mul_sel = spf_pkg::MUL_W_PREV;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL_WX;
        end
      end
      ST_MUL_WX: begin
        cmd_o.mul_sel  = spf_pkg::MUL_W_PREV;
        cmd_o.mul_axis = spf_pkg::AXIS_X;
        state_d        = ST_MUL_PX;
      end
      ST_MUL_PX: begin
        cmd_o.mul_sel  = spf_pkg::MUL_WC_PEN;
        cmd_o.mul_axis = spf_pkg::AXIS_X;
        cmd_o.acc_load = 1'b1;
        state_d        = ST_MUL_WY;
      end
      ST_MUL_WY: begin
        cmd_o.mul_sel  = spf_pkg::MUL_W_PREV;
        cmd_o.mul_axis = spf_pkg::AXIS_Y;
        cmd_o.sm_write = 1'b1;
        cmd_o.wr_axis  = spf_pkg::AXIS_X;
        state_d        = ST_MUL_PY;
      end
      ST_MUL_PY: begin
        cmd_o.mul_sel  = spf_pkg::MUL_WC_PEN;
        cmd_o.mul_axis = spf_pkg::AXIS_Y;
        cmd_o.acc_load = 1'b1;
        state_d        = ST_MUL_GX;
      end
      ST_MUL_GX: begin
        cmd_o.mul_sel  = spf_pkg::MUL_DELTA_GAIN;
        cmd_o.mul_axis = spf_pkg::AXIS_X;
        cmd_o.sm_write = 1'b1;
        cmd_o.wr_axis  = spf_pkg::AXIS_Y;
        state_d        = ST_MUL_GY;
      end
      ST_MUL_GY: begin
        cmd_o.mul_sel  = spf_pkg::MUL_DELTA_GAIN;
        cmd_o.mul_axis = spf_pkg::AXIS_Y;
        cmd_o.mv_write = 1'b1;
        cmd_o.wr_axis  = spf_pkg::AXIS_X;
        state_d        = ST_RND_Y;
      end
      ST_RND_Y: begin
        cmd_o.mv_write = 1'b1;
        cmd_o.wr_axis  = spf_pkg::AXIS_Y;
        state_d        = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the result register can take the new request
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

[rtl/spf_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spf_dp
// Datapath: shared signed multiplier, smoothing accumulator, move rounding,
// clamp, dead band and command timer, plus the result register.
// ----------------------------------------------------------------------------
module spf_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire spf_pkg::cmd_t cmd_i,
  input  wire spf_pkg::cfg_t cfg_i,
  input  wire logic [15:0]   pen_x_i,
  input  wire logic [15:0]   pen_y_i,
  input  wire logic [31:0]   time_ms_i,
  output logic               position_updated_o,
  output logic               command_issued_o,
  output logic [17:0]        position_x_o,
  output logic [17:0]        position_y_o
);

  // captured sample
  logic [15:0] pen_x_q, pen_y_q;
  logic [31:0] time_q;

  // follower state
  logic [31:0] sm_x_q, sm_y_q;
  logic [17:0] cur_x_q, cur_y_q;
  logic [31:0] last_time_q;
  logic        armed_q;

  // working registers
  logic signed [56:0] prod_q;
  logic [47:0]        acc_q;
  logic signed [33:0] move_x_q, move_y_q;

  // result register
  logic        res_upd_q, res_cmd_q;
  logic [17:0] res_x_q, res_y_q;

  // multiplier operands
  logic [31:0]        sm_sel;
  logic [15:0]        pen_sel;
  logic [15:0]        target_sel;
  logic signed [23:0] gain_sel;
  logic [16:0]        w_comp;
  logic signed [33:0] delta;
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] mul_full;

  logic [48:0]        sm_sum;
  logic [31:0]        sm_new;
  logic               prod_neg;
  logic [56:0]        prod_mag;
  logic [56:0]        mag_rnd;
  logic [32:0]        mv_mag;
  logic signed [33:0] move_d;

  logic        exceed;
  logic [17:0] new_x, new_y;
  logic [31:0] elapsed;
  logic        due;

  function automatic logic [17:0] clamp_pos(input logic [17:0]        cur,
                                            input logic signed [33:0] mv,
                                            input logic [9:0]         limit_mm);
    logic signed [34:0] sum;
    logic [17:0]        lim;
    begin
      sum = $signed({17'd0, cur}) + $signed({mv[33], mv});
      lim = {limit_mm, 8'd0};
      if (sum[34]) begin
        clamp_pos = 18'd0;
      end else if (sum > $signed({17'd0, lim})) begin
        clamp_pos = lim;
      end else begin
        clamp_pos = sum[17:0];
      end
    end
  endfunction

  assign sm_sel     = (cmd_i.mul_axis == spf_pkg::AXIS_Y) ? sm_y_q : sm_x_q;
  assign pen_sel    = (cmd_i.mul_axis == spf_pkg::AXIS_Y) ? pen_y_q : pen_x_q;
  assign target_sel = (cmd_i.mul_axis == spf_pkg::AXIS_Y) ? cfg_i.target_y : cfg_i.target_x;
  assign gain_sel   = (cmd_i.mul_axis == spf_pkg::AXIS_Y) ? cfg_i.gain_y : cfg_i.gain_x;
  assign w_comp     = 17'h10000 - {1'b0, cfg_i.smoothing_weight};
  assign delta      = $signed({2'b00, sm_sel}) - $signed({2'b00, target_sel, 16'h0000});

  always_comb begin
    case (cmd_i.mul_sel)
      spf_pkg::MUL_W_PREV: begin
        mul_a = $signed({2'b00, sm_sel});
        mul_b = $signed({9'd0, cfg_i.smoothing_weight});
      end
      spf_pkg::MUL_WC_PEN: begin
        mul_a = $signed({18'd0, pen_sel});
        mul_b = $signed({8'd0, w_comp});
      end
      spf_pkg::MUL_DELTA_GAIN: begin
        mul_a = delta;
        mul_b = $signed({gain_sel[23], gain_sel});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // smoothed = (w*prev + (1-w)*(pen<<16) + half) >> 16
  assign sm_sum = {1'b0, acc_q} + {prod_q[32:0], 16'h0000} + spf_pkg::HalfQ16;
  assign sm_new = sm_sum[47:16];

  // round the Q.32 product to Q.8, half away from zero
  assign prod_neg = prod_q[56];
  assign prod_mag = prod_neg ? 57'(-prod_q) : 57'(prod_q);
  assign mag_rnd  = prod_mag + spf_pkg::HalfQ24;
  assign mv_mag   = mag_rnd[56:24];
  assign move_d   = prod_neg ? -$signed({1'b0, mv_mag}) : $signed({1'b0, mv_mag});

  assign exceed = (move_x_q > spf_pkg::DeadbandQ8) || (move_x_q < -spf_pkg::DeadbandQ8) ||
                  (move_y_q > spf_pkg::DeadbandQ8) || (move_y_q < -spf_pkg::DeadbandQ8);
  assign new_x   = clamp_pos(cur_x_q, move_x_q, cfg_i.travel_limit_x);
  assign new_y   = clamp_pos(cur_y_q, move_y_q, cfg_i.travel_limit_y);
  assign elapsed = time_q - last_time_q;
  assign due     = (elapsed >= {24'd0, cfg_i.min_interval_ms});

  // payload and work registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[56:0];
    if (cmd_i.capture) begin
      pen_x_q <= pen_x_i;
      pen_y_q <= pen_y_i;
      time_q  <= time_ms_i;
    end
    if (cmd_i.acc_load) begin
      acc_q <= prod_q[47:0];
    end
    if (cmd_i.mv_write) begin
      if (cmd_i.wr_axis == spf_pkg::AXIS_Y) begin
        move_y_q <= move_d;
      end else begin
        move_x_q <= move_d;
      end
    end
    if (cmd_i.commit) begin
      res_upd_q <= exceed;
      res_cmd_q <= exceed && armed_q && due;
      res_x_q   <= exceed ? new_x : cur_x_q;
      res_y_q   <= exceed ? new_y : cur_y_q;
    end
  end

  // follower state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_x_q      <= 32'd0;
      sm_y_q      <= 32'd0;
      cur_x_q     <= 18'd0;
      cur_y_q     <= 18'd0;
      last_time_q <= 32'd0;
      armed_q     <= 1'b0;
    end else begin
      if (cmd_i.sm_write) begin
        if (cmd_i.wr_axis == spf_pkg::AXIS_Y) begin
          sm_y_q <= sm_new;
        end else begin
          sm_x_q <= sm_new;
        end
      end
      if (cmd_i.commit && exceed) begin
        cur_x_q <= new_x;
        cur_y_q <= new_y;
        // first update only arms the timer
        if (!armed_q) begin
          armed_q     <= 1'b1;
          last_time_q <= time_q;
        end else if (due) begin
          last_time_q <= time_q;
        end
      end
    end
  end

  assign position_updated_o = res_upd_q;
  assign command_issued_o   = res_cmd_q;
  assign position_x_o       = res_x_q;
  assign position_y_o       = res_y_q;

endmodule
`default_nettype wire

[rtl/smoothed_pen_position_follower_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smoothed_pen_position_follower_core
// Exponential smoothing, dead band and rate-limited motor command follower.
//
//   channel    | dir | handshake            | payload
//   -----------+-----+----------------------+----------------------------------
//   sample_i   | in  | valid/ready          | pen_x, pen_y, time_ms
//   result_o   | out | valid/ready          | position_updated, command_issued,
//              |     |                      | position_x, position_y
//   apb        | in  | psel/penable/pready  | paddr, pwdata, prdata
//
// A request steps through the multiply states, RND_Y and COMMIT to the result
// register; the next sample is accepted only back in IDLE, after that commit.
// The steps are set by the single 34x25 multiplier used six times per request.
// rst_ni clears the smoothing state, positions, timer and both handshakes.
// A result waiting on result_o does not block acceptance; only the final
// commit step waits for the result register to free up.
// ----------------------------------------------------------------------------
module smoothed_pen_position_follower_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  spf_in_if.sink                          sample_i,
  spf_out_if.source                       result_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [spf_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  spf_pkg::cfg_t cfg;
  spf_pkg::cmd_t cmd;

  spf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  spf_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg),
    .pen_x_i            (sample_i.pen_x),
    .pen_y_i            (sample_i.pen_y),
    .time_ms_i          (sample_i.time_ms),
    .position_updated_o (result_o.position_updated),
    .command_issued_o   (result_o.command_issued),
    .position_x_o       (result_o.position_x),
    .position_y_o       (result_o.position_y)
  );

  // a new result shows up only after a commit step
  a_rise_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(cmd.commit))
    else $error("result valid rose without a commit");

  // commit never overwrites a result that is still waiting
  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!result_o.valid || result_o.ready))
    else $error("commit while result register occupied");

  // no sample is taken during the commit step
  a_no_accept_in_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !sample_i.ready)
    else $error("sample accepted during commit");

  // a motor command implies a position update
  a_cmd_needs_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.command_issued) |-> result_o.position_updated)
    else $error("command issued without position update");

endmodule
`default_nettype wire
